@@ hdl/ptb_pkg.sv @@
// Shared constants and types for the palindromic tree builder.
`default_nettype none
package ptb_pkg;
   localparam int MAX_TEXT_DEF = 4096;
   localparam int ALPHABET_DEF = 26;
   localparam int SYM_W        = 5;
   localparam int OUT_W        = 13;
   localparam int REQ_DATA_W   = 8;
   localparam int RSP_DATA_W   = 56;
   localparam int RSP_USER_W   = 2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WALK,
      ST_NODE_RSP,
      ST_TEXT_RSP,
      ST_CHILD_RD,
      ST_CHILD_RSP,
      ST_CHK_RSP,
      ST_CREATE,
      ST_DONE
   } ptb_state_type;

   // node memory strobes
   typedef struct packed {
      logic rd;
      logic text_we;
      logic node_we;
      logic occ_we;
   } ptb_nmem_ctl_type;

   typedef struct packed {
      logic             is_new;
      logic [OUT_W-1:0] node_index;
      logic [OUT_W-1:0] pal_length;
      logic [OUT_W-1:0] occurrence_count;
      logic [OUT_W-1:0] unique_count;
      logic             overflow;
   } ptb_result_type;
endpackage
`default_nettype wire

@@ hdl/palindromic_tree_builder.sv @@
// Top level of the online palindromic tree (eertree) builder.
//
//  channel | direction | tdata (low bit up)                          | tuser
//  req_    | in        | symbol[4:0], zero pad to 8 bits             | -
//  rsp_    | out       | node_index, pal_length, occurrence_count,   | is_new, overflow
//          |           | unique_count (13 bits each), pad to 56 bits |
//
// One symbol at a time. Each suffix-link step is a node read, then a text read
// when the node's palindrome fits, on the single node RAM port; child lookup and
// check follow, then node creation, plus accept and handoff. Overflowed symbols
// skip straight from accept to handoff.
// Reset is synchronous; the RAMs need no clearing pass since every child entry
// is checked against the node count and a parent back-pointer before use, and
// the two roots' fields come from constants rather than the node RAM.
// A held result stalls only the next completion, not the next accept.
`default_nettype none
module palindromic_tree_builder #(
   parameter int MAX_TEXT = ptb_pkg::MAX_TEXT_DEF,
   parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [ptb_pkg::REQ_DATA_W-1:0]    req_tdata,  // symbol
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // node_index, pal_length, occurrence_count, unique_count
   output logic [ptb_pkg::RSP_DATA_W-1:0]         rsp_tdata,
   output logic [ptb_pkg::RSP_USER_W-1:0]         rsp_tuser   // is_new, overflow
);
   localparam int NW = $clog2(MAX_TEXT + 3);
   localparam int AW = $clog2(MAX_TEXT + 2);
   localparam int CW = $clog2((MAX_TEXT + 2) * ALPHABET);
   localparam int SW = ptb_pkg::SYM_W;

   ptb_pkg::ptb_result_type   res;
   logic                      res_valid;
   logic                      res_ack;
   ptb_pkg::ptb_nmem_ctl_type nm_ctl;
   logic [AW-1:0]             nm_addr;
   logic [SW-1:0]             nm_wr_text, nm_wr_sym, nm_rd_text, nm_rd_sym;
   logic [NW-1:0]             nm_wr_link, nm_wr_len, nm_wr_occ, nm_wr_parent;
   logic [NW-1:0]             nm_rd_link, nm_rd_len, nm_rd_occ, nm_rd_parent;
   logic                      cm_rd, cm_we;
   logic [CW-1:0]             cm_addr;
   logic [NW-1:0]             cm_wdata, cm_rdata;

   logic                              rsp_valid_ff;
   logic [ptb_pkg::RSP_DATA_W-1:0]    rsp_data_ff;
   logic [ptb_pkg::RSP_USER_W-1:0]    rsp_user_ff;

   ptb_seq #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_sym      (req_tdata[SW-1:0]),
      .req_ready    (req_tready),
      .res          (res),
      .res_valid    (res_valid),
      .res_ack      (res_ack),
      .nm_ctl       (nm_ctl),
      .nm_addr      (nm_addr),
      .nm_wr_text   (nm_wr_text),
      .nm_wr_link   (nm_wr_link),
      .nm_wr_len    (nm_wr_len),
      .nm_wr_occ    (nm_wr_occ),
      .nm_wr_parent (nm_wr_parent),
      .nm_wr_sym    (nm_wr_sym),
      .nm_rd_text   (nm_rd_text),
      .nm_rd_link   (nm_rd_link),
      .nm_rd_len    (nm_rd_len),
      .nm_rd_occ    (nm_rd_occ),
      .nm_rd_parent (nm_rd_parent),
      .nm_rd_sym    (nm_rd_sym),
      .cm_rd        (cm_rd),
      .cm_we        (cm_we),
      .cm_addr      (cm_addr),
      .cm_wdata     (cm_wdata),
      .cm_rdata     (cm_rdata)
   );

   ptb_node_mem #(.MAX_TEXT(MAX_TEXT)) u_node_mem (
      .clock     (clock),
      .ctl       (nm_ctl),
      .addr      (nm_addr),
      .wr_text   (nm_wr_text),
      .wr_link   (nm_wr_link),
      .wr_len    (nm_wr_len),
      .wr_occ    (nm_wr_occ),
      .wr_parent (nm_wr_parent),
      .wr_sym    (nm_wr_sym),
      .rd_text   (nm_rd_text),
      .rd_link   (nm_rd_link),
      .rd_len    (nm_rd_len),
      .rd_occ    (nm_rd_occ),
      .rd_parent (nm_rd_parent),
      .rd_sym    (nm_rd_sym)
   );

   ptb_child_mem #(.MAX_TEXT(MAX_TEXT), .ALPHABET(ALPHABET)) u_child_mem (
      .clock (clock),
      .rd    (cm_rd),
      .we    (cm_we),
      .addr  (cm_addr),
      .wdata (cm_wdata),
      .rdata (cm_rdata)
   );

   // output register: result moves in once the previous transaction is gone
   assign res_ack = res_valid && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ack) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ack) begin
         rsp_data_ff <= ptb_pkg::RSP_DATA_W'({res.unique_count, res.occurrence_count,
                                              res.pal_length, res.node_index});
         rsp_user_ff <= {res.overflow, res.is_new};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
endmodule
`default_nettype wire

@@ hdl/ptb_node_mem.sv @@
// Node store and text store sharing one single-port synchronous RAM.
`default_nettype none
module ptb_node_mem #(
   parameter int MAX_TEXT = ptb_pkg::MAX_TEXT_DEF
) (
   input  wire logic                       clock,
   input  wire ptb_pkg::ptb_nmem_ctl_type  ctl,
   input  wire logic [$clog2(MAX_TEXT+2)-1:0] addr,
   input  wire logic [ptb_pkg::SYM_W-1:0]  wr_text,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] wr_link,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] wr_len,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] wr_occ,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] wr_parent,
   input  wire logic [ptb_pkg::SYM_W-1:0]  wr_sym,
   output logic [ptb_pkg::SYM_W-1:0]       rd_text,
   output logic [$clog2(MAX_TEXT+3)-1:0]   rd_link,
   output logic [$clog2(MAX_TEXT+3)-1:0]   rd_len,
   output logic [$clog2(MAX_TEXT+3)-1:0]   rd_occ,
   output logic [$clog2(MAX_TEXT+3)-1:0]   rd_parent,
   output logic [ptb_pkg::SYM_W-1:0]       rd_sym
);
   localparam int DEPTH  = MAX_TEXT + 2;
   localparam int NW     = $clog2(MAX_TEXT + 3);
   localparam int SW     = ptb_pkg::SYM_W;
   localparam int NODE_W = 4 * NW + SW;
   localparam int WORD_W = NODE_W + SW;
   localparam int SYM_LO = SW;
   localparam int PAR_LO = 2 * SW;
   localparam int OCC_LO = 2 * SW + NW;
   localparam int LEN_LO = 2 * SW + 2 * NW;
   localparam int LNK_LO = 2 * SW + 3 * NW;

   // word: text, sym, parent, occ, len, link from the low end
   logic [WORD_W-1:0] node_ram [DEPTH];
   logic [WORD_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (ctl.text_we) begin
         node_ram[addr][0 +: SW] <= wr_text;
      end
      if (ctl.node_we) begin
         node_ram[addr][SYM_LO +: NODE_W] <= {wr_link, wr_len, wr_occ, wr_parent, wr_sym};
      end
      if (ctl.occ_we) begin
         node_ram[addr][OCC_LO +: NW] <= wr_occ;
      end
      if (ctl.rd) begin
         rd_ff <= node_ram[addr];
      end
   end

   assign rd_text   = rd_ff[0 +: SW];
   assign rd_sym    = rd_ff[SYM_LO +: SW];
   assign rd_parent = rd_ff[PAR_LO +: NW];
   assign rd_occ    = rd_ff[OCC_LO +: NW];
   assign rd_len    = rd_ff[LEN_LO +: NW];
   assign rd_link   = rd_ff[LNK_LO +: NW];
endmodule
`default_nettype wire

@@ hdl/ptb_child_mem.sv @@
// Child table RAM: one entry per (node, symbol), one port, registered read.
`default_nettype none
module ptb_child_mem #(
   parameter int MAX_TEXT = ptb_pkg::MAX_TEXT_DEF,
   parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       rd,
   input  wire logic                                       we,
   input  wire logic [$clog2((MAX_TEXT+2)*ALPHABET)-1:0]   addr,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0]              wdata,
   output logic [$clog2(MAX_TEXT+3)-1:0]                   rdata
);
   localparam int DEPTH = (MAX_TEXT + 2) * ALPHABET;
   localparam int NW    = $clog2(MAX_TEXT + 3);

   logic [NW-1:0] child_ram [DEPTH];
   logic [NW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         child_ram[addr] <= wdata;
      end
      if (rd) begin
         rdata_ff <= child_ram[addr];
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ hdl/ptb_seq.sv @@
// Sequencer: suffix-link walks, child lookup, node creation and counters.
`default_nettype none
module ptb_seq #(
   parameter int MAX_TEXT = ptb_pkg::MAX_TEXT_DEF,
   parameter int ALPHABET = ptb_pkg::ALPHABET_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   input  wire logic [ptb_pkg::SYM_W-1:0]    req_sym,
   output logic                              req_ready,
   output ptb_pkg::ptb_result_type           res,
   output logic                              res_valid,
   input  wire logic                         res_ack,
   output ptb_pkg::ptb_nmem_ctl_type         nm_ctl,
   output logic [$clog2(MAX_TEXT+2)-1:0]     nm_addr,
   output logic [ptb_pkg::SYM_W-1:0]         nm_wr_text,
   output logic [$clog2(MAX_TEXT+3)-1:0]     nm_wr_link,
   output logic [$clog2(MAX_TEXT+3)-1:0]     nm_wr_len,
   output logic [$clog2(MAX_TEXT+3)-1:0]     nm_wr_occ,
   output logic [$clog2(MAX_TEXT+3)-1:0]     nm_wr_parent,
   output logic [ptb_pkg::SYM_W-1:0]         nm_wr_sym,
   input  wire logic [ptb_pkg::SYM_W-1:0]    nm_rd_text,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] nm_rd_link,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] nm_rd_len,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] nm_rd_occ,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] nm_rd_parent,
   input  wire logic [ptb_pkg::SYM_W-1:0]    nm_rd_sym,
   output logic                              cm_rd,
   output logic                              cm_we,
   output logic [$clog2((MAX_TEXT+2)*ALPHABET)-1:0] cm_addr,
   output logic [$clog2(MAX_TEXT+3)-1:0]     cm_wdata,
   input  wire logic [$clog2(MAX_TEXT+3)-1:0] cm_rdata
);
   localparam int NW    = $clog2(MAX_TEXT + 3);
   localparam int AW    = $clog2(MAX_TEXT + 2);
   localparam int TW    = $clog2(MAX_TEXT + 1);
   localparam int CW    = $clog2((MAX_TEXT + 2) * ALPHABET);
   localparam int PW    = NW + 1;
   localparam int OW    = ptb_pkg::OUT_W;
   localparam int SW    = ptb_pkg::SYM_W;

   ptb_pkg::ptb_state_type state_ff, state_in;
   logic [TW-1:0] tl_ff, tl_in;
   logic [NW-1:0] nt_ff, nt_in;
   logic [NW-1:0] last_ff, last_in;
   logic [SW-1:0] sym_ff, sym_in;
   logic [NW-1:0] cur_ff, cur_in;
   logic [NW-1:0] len_ff, len_in;
   logic [NW-1:0] link_ff, link_in;
   logic [NW-1:0] par_ff, par_in;
   logic [NW-1:0] newlen_ff, newlen_in;
   logic [NW-1:0] plink_ff, plink_in;
   logic          pnone_ff, pnone_in;
   logic          walk2_ff, walk2_in;
   logic [NW-1:0] cand_ff, cand_in;
   logic [NW-1:0] lnk_ff, lnk_in;
   ptb_pkg::ptb_result_type res_ff, res_in;
   logic          found, miss, ovf;
   logic [PW-1:0] pos;
   logic [NW-1:0] occ_inc;
   logic [NW-1:0] node_len_rd, node_link_rd;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ptb_pkg::ST_IDLE;
         tl_ff    <= '0;
         nt_ff    <= NW'(2);
         last_ff  <= '0;
      end else begin
         state_ff <= state_in;
         tl_ff    <= tl_in;
         nt_ff    <= nt_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff    <= sym_in;
      cur_ff    <= cur_in;
      len_ff    <= len_in;
      link_ff   <= link_in;
      par_ff    <= par_in;
      newlen_ff <= newlen_in;
      plink_ff  <= plink_in;
      pnone_ff  <= pnone_in;
      walk2_ff  <= walk2_in;
      cand_ff   <= cand_in;
      lnk_ff    <= lnk_in;
      res_ff    <= res_in;
   end

   // empty root: length 0, link to the imaginary root, never stored in RAM
   assign node_len_rd  = (cur_ff == NW'(1)) ? '0 : nm_rd_len;
   assign node_link_rd = (cur_ff == NW'(1)) ? '0 : nm_rd_link;

   assign ovf = (9'(req_sym) >= 9'(ALPHABET)) || (32'(tl_ff) >= 32'(MAX_TEXT))
                || (32'(nt_ff) >= 32'(MAX_TEXT + 2));
   assign pos     = PW'(tl_ff) - PW'(node_len_rd) - PW'(2);
   assign occ_inc = nm_rd_occ + NW'(1);

   always_comb begin
      state_in  = state_ff;
      tl_in     = tl_ff;
      nt_in     = nt_ff;
      last_in   = last_ff;
      sym_in    = sym_ff;
      cur_in    = cur_ff;
      len_in    = len_ff;
      link_in   = link_ff;
      par_in    = par_ff;
      newlen_in = newlen_ff;
      plink_in  = plink_ff;
      pnone_in  = pnone_ff;
      walk2_in  = walk2_ff;
      cand_in   = cand_ff;
      lnk_in    = lnk_ff;
      res_in    = res_ff;
      found     = 1'b0;
      miss      = 1'b0;
      nm_ctl    = '0;
      nm_addr   = '0;
      nm_wr_text   = '0;
      nm_wr_link   = '0;
      nm_wr_len    = '0;
      nm_wr_occ    = '0;
      nm_wr_parent = '0;
      nm_wr_sym    = '0;
      cm_rd    = 1'b0;
      cm_we    = 1'b0;
      cm_addr  = '0;
      cm_wdata = '0;

      unique case (state_ff)
         ptb_pkg::ST_IDLE: begin
            if (req_valid) begin
               sym_in = req_sym;
               if (ovf) begin
                  res_in = '0;
                  res_in.overflow     = 1'b1;
                  res_in.unique_count = OW'(nt_ff - NW'(2));
                  state_in = ptb_pkg::ST_DONE;
               end else begin
                  nm_ctl.text_we = 1'b1;
                  nm_addr    = AW'(tl_ff);
                  nm_wr_text = req_sym;
                  tl_in      = tl_ff + TW'(1);
                  cur_in     = last_ff;
                  walk2_in   = 1'b0;
                  state_in   = ptb_pkg::ST_WALK;
               end
            end
         end
         ptb_pkg::ST_WALK: begin
            // imaginary root always extends
            if (cur_ff == '0) begin
               found = 1'b1;
            end else begin
               nm_ctl.rd = 1'b1;
               nm_addr   = AW'(cur_ff);
               state_in  = ptb_pkg::ST_NODE_RSP;
            end
         end
         ptb_pkg::ST_NODE_RSP: begin
            len_in  = node_len_rd;
            link_in = node_link_rd;
            if (PW'(tl_ff) < PW'(node_len_rd) + PW'(2)) begin
               cur_in   = node_link_rd;
               state_in = ptb_pkg::ST_WALK;
            end else begin
               nm_ctl.rd = 1'b1;
               nm_addr   = AW'(pos);
               state_in  = ptb_pkg::ST_TEXT_RSP;
            end
         end
         ptb_pkg::ST_TEXT_RSP: begin
            if (nm_rd_text == sym_ff) begin
               found = 1'b1;
            end else begin
               cur_in   = link_ff;
               state_in = ptb_pkg::ST_WALK;
            end
         end
         ptb_pkg::ST_CHILD_RD: begin
            cm_rd    = 1'b1;
            cm_addr  = CW'(cur_ff) * CW'(ALPHABET) + CW'(sym_ff);
            state_in = ptb_pkg::ST_CHILD_RSP;
         end
         ptb_pkg::ST_CHILD_RSP: begin
            // entry is trusted only if it names a live node that points back here
            if ((cm_rdata >= NW'(2)) && (cm_rdata < nt_ff)) begin
               nm_ctl.rd = 1'b1;
               nm_addr   = AW'(cm_rdata);
               cand_in   = cm_rdata;
               state_in  = ptb_pkg::ST_CHK_RSP;
            end else begin
               miss = 1'b1;
            end
         end
         ptb_pkg::ST_CHK_RSP: begin
            if ((nm_rd_parent == cur_ff) && (nm_rd_sym == sym_ff)) begin
               if (walk2_ff) begin
                  lnk_in   = cand_ff;
                  state_in = ptb_pkg::ST_CREATE;
               end else begin
                  nm_ctl.occ_we = 1'b1;
                  nm_addr   = AW'(cand_ff);
                  nm_wr_occ = occ_inc;
                  last_in   = cand_ff;
                  res_in.is_new           = 1'b0;
                  res_in.node_index       = OW'(cand_ff);
                  res_in.pal_length       = OW'(nm_rd_len);
                  res_in.occurrence_count = OW'(occ_inc);
                  res_in.unique_count     = OW'(nt_ff - NW'(2));
                  res_in.overflow         = 1'b0;
                  state_in = ptb_pkg::ST_DONE;
               end
            end else begin
               miss = 1'b1;
            end
         end
         ptb_pkg::ST_CREATE: begin
            nm_ctl.node_we = 1'b1;
            nm_addr      = AW'(nt_ff);
            nm_wr_link   = lnk_ff;
            nm_wr_len    = newlen_ff;
            nm_wr_occ    = NW'(1);
            nm_wr_parent = par_ff;
            nm_wr_sym    = sym_ff;
            cm_we    = 1'b1;
            cm_addr  = CW'(par_ff) * CW'(ALPHABET) + CW'(sym_ff);
            cm_wdata = nt_ff;
            nt_in    = nt_ff + NW'(1);
            last_in  = nt_ff;
            res_in.is_new           = 1'b1;
            res_in.node_index       = OW'(nt_ff);
            res_in.pal_length       = OW'(newlen_ff);
            res_in.occurrence_count = OW'(1);
            res_in.unique_count     = OW'(nt_ff - NW'(1));
            res_in.overflow         = 1'b0;
            state_in = ptb_pkg::ST_DONE;
         end
         ptb_pkg::ST_DONE: begin
            if (res_ack) begin
               state_in = ptb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ptb_pkg::ST_IDLE;
         end
      endcase

      if (found) begin
         if (!walk2_ff) begin
            par_in    = cur_ff;
            pnone_in  = (cur_ff == '0);
            plink_in  = link_ff;
            newlen_in = (cur_ff == '0) ? NW'(1) : len_ff + NW'(2);
         end
         state_in = ptb_pkg::ST_CHILD_RD;
      end

      if (miss) begin
         if (walk2_ff || pnone_ff) begin
            lnk_in   = NW'(1);
            state_in = ptb_pkg::ST_CREATE;
         end else begin
            walk2_in = 1'b1;
            cur_in   = plink_ff;
            state_in = ptb_pkg::ST_WALK;
         end
      end
   end

   assign req_ready = (state_ff == ptb_pkg::ST_IDLE);
   assign res_valid = (state_ff == ptb_pkg::ST_DONE);
   assign res       = res_ff;
endmodule
`default_nettype wire

@@ hdl/ptb_checker.sv @@
// Port-level assertions for the palindromic tree builder, bound to the top.
`default_nettype none
module ptb_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [ptb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [ptb_pkg::RSP_USER_W-1:0] rsp_tuser
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_ovf_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata[38:0] == 39'd0)
      else $error("overflow result carries node data");

   a_new_once: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[38:26] == 13'd1)
      else $error("new node without a single occurrence");

   a_real_node: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[12:0] >= 13'd2 && rsp_tdata[25:13] != 13'd0)
      else $error("result names a root");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && (req_tready || !req_tvalid || req_tready == 1'b1))
      else $error("result valid right after reset");
endmodule

bind palindromic_tree_builder ptb_checker u_ptb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire

@@ dv/palindromic_tree_builder_tb.sv @@
// Self-checking testbench for the palindromic tree builder: predicts each result, checks it.
`default_nettype none
module palindromic_tree_builder_tb;

   localparam int TEXT_CAP   = ptb_pkg::MAX_TEXT_DEF;
   localparam int SIGMA      = ptb_pkg::ALPHABET_DEF;
   localparam int NODE_LIMIT = TEXT_CAP + 2;
   localparam int SYM_W      = ptb_pkg::SYM_W;
   localparam int OUT_W      = ptb_pkg::OUT_W;
   localparam int REQ_DATA_W = ptb_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W = ptb_pkg::RSP_DATA_W;
   localparam int RSP_USER_W = ptb_pkg::RSP_USER_W;
   localparam int IDLE_LIMIT = 60000;  // idle bound for the watchdog, sized for the longest suffix walk

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // symbol
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // node_index, pal_length, occurrence_count, unique_count
   logic [RSP_USER_W-1:0] rsp_tuser;   // is_new, overflow

   palindromic_tree_builder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   // predictor state: mirror of the tree
   logic [SYM_W-1:0] text_mem [TEXT_CAP];
   int               text_len;
   int               sfx_link    [NODE_LIMIT];
   int               pal_len     [NODE_LIMIT];
   int               occ_cnt     [NODE_LIMIT];
   int               edge_to     [NODE_LIMIT*SIGMA];
   int               node_cnt;
   int               tail_node;

   logic [SYM_W-1:0]        symbol_queue [$];   // symbols waiting to be driven
   ptb_pkg::ptb_result_type result_queue [$];   // predicted results, oldest first

   int  mismatches  = 0;
   int  symbols_in  = 0;
   int  results_out = 0;
   int  new_nodes   = 0;
   int  overflows   = 0;
   int  longest     = 0;
   bit  calm        = 0;   // no idling on either side
   int  send_gap    = 0;
   int  recv_gap    = 0;
   int  idle_cycles = 0;

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // true when node n's palindrome, with s on both sides, ends the text
   function automatic bit grows_by(int n, logic [SYM_W-1:0] s);
      int pos;
      if (n < 0 || n >= node_cnt) return 0;
      pos = text_len - 2 - pal_len[n];
      if (pos < 0 || pos >= text_len) return 0;
      return text_mem[pos] == s;
   endfunction

   function automatic ptb_pkg::ptb_result_type tree_append(logic [SYM_W-1:0] s);
      ptb_pkg::ptb_result_type r;
      int par, lk, v, c;
      r = '0;
      if (s >= SIGMA || text_len >= TEXT_CAP || node_cnt >= NODE_LIMIT) begin
         r.unique_count = OUT_W'(node_cnt - 2);
         r.overflow     = 1'b1;
         return r;
      end
      text_mem[text_len] = s;
      text_len++;
      par = tail_node;
      while (par > 0 && !grows_by(par, s)) par = sfx_link[par];
      if (par < 0) par = 0;
      v = edge_to[par*SIGMA + s];
      if (v >= 0 && v < node_cnt) begin
         occ_cnt[v]++;
      end else begin
         lk = sfx_link[par];
         while (lk >= 0 && !grows_by(lk, s)) lk = sfx_link[lk];
         if (lk >= 0) begin
            c  = edge_to[lk*SIGMA + s];
            lk = (c >= 0 && c < node_cnt) ? c : -1;
         end
         if (lk < 0) lk = 1;   // fallback to the empty root
         v = node_cnt;
         edge_to[par*SIGMA + s] = v;
         sfx_link[v] = lk;
         pal_len[v]  = pal_len[par] + 2;
         occ_cnt[v]  = 1;
         node_cnt++;
         r.is_new = 1'b1;
      end
      tail_node          = v;
      r.node_index       = OUT_W'(v);
      r.pal_length       = OUT_W'(pal_len[v]);
      r.occurrence_count = OUT_W'(occ_cnt[v]);
      r.unique_count     = OUT_W'(node_cnt - 2);
      return r;
   endfunction

   // driver: presents queued symbols, predicts on each accepted transaction
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            ptb_pkg::ptb_result_type p;
            p = tree_append(req_tdata[SYM_W-1:0]);
            result_queue = {result_queue, p};
            symbols_in++;
            if (p.is_new) new_nodes++;
            if (p.overflow) overflows++;
            if (p.pal_length > longest) longest = p.pal_length;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (symbol_queue.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W-SYM_W){1'b0}}, symbol_queue.pop_front()};
               if (!calm && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 14);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: checks each accepted result against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            ptb_pkg::ptb_result_type got, want;
            got.node_index       = rsp_tdata[12:0];
            got.pal_length       = rsp_tdata[25:13];
            got.occurrence_count = rsp_tdata[38:26];
            got.unique_count     = rsp_tdata[51:39];
            got.is_new           = rsp_tuser[0];
            got.overflow         = rsp_tuser[1];
            results_out++;
            if (result_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result transaction %p", got);
            end else begin
               want = result_queue.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("result %0d mismatch: expected %p, got %p",
                              results_out, want, got);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 14);
         end
      end
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // random word over a narrow alphabet; half of them mirrored into palindromes
   task automatic add_word();
      logic [SYM_W-1:0] w [$];
      int n, base, span;
      n    = $urandom_range(1, 12);
      span = $urandom_range(1, 3);
      base = $urandom_range(0, SIGMA - span);
      for (int i = 0; i < n; i++) w = {w, SYM_W'(base + $urandom_range(0, span - 1))};
      foreach (w[i]) symbol_queue = {symbol_queue, w[i]};
      if ($urandom_range(0, 1)) begin
         if ($urandom_range(0, 1)) void'(w.pop_back());   // odd center
         for (int i = w.size() - 1; i >= 0; i--) symbol_queue = {symbol_queue, w[i]};
      end
   endtask

   task automatic wait_drained();
      while (symbol_queue.size() > 0 || req_tvalid || result_queue.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [SYM_W-1:0] directed [23];
      for (int i = 0; i < NODE_LIMIT*SIGMA; i++) edge_to[i] = -1;
      sfx_link[0] = -1;  pal_len[0] = -1;  occ_cnt[0] = 1;
      sfx_link[1] = 0;   pal_len[1] = 0;   occ_cnt[1] = 1;
      text_len = 0;  node_cnt = 2;  tail_node = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: alphabet ends, out-of-alphabet symbols, runs, nested palindromes
      directed = '{5'd0, 5'd25, 5'd26, 5'd31, 5'd0, 5'd0, 5'd0, 5'd0, 5'd1, 5'd0,
                   5'd1, 5'd0, 5'd2, 5'd0, 5'd1, 5'd0, 5'd1, 5'd0, 5'd30, 5'd25,
                   5'd25, 5'd10, 5'd21};
      foreach (directed[i]) symbol_queue = {symbol_queue, directed[i]};

      // random: mostly structured words, some noise and invalid symbols
      while (symbol_queue.size() < 1600) begin
         case ($urandom_range(0, 9))
            0:       symbol_queue = {symbol_queue, SYM_W'($urandom_range(0, 31))};
            1:       symbol_queue = {symbol_queue, SYM_W'($urandom_range(SIGMA, 31))};
            default: add_word();
         endcase
      end
      // wait until every queued symbol is sent and every result has returned
      wait_drained();

      // closing stretch without idling on either side
      calm = 1;
      while (symbol_queue.size() < 40) add_word();
      symbol_queue = {symbol_queue, 5'd31};
      symbol_queue = {symbol_queue, 5'd0};
      symbol_queue = {symbol_queue, 5'd26};
      symbol_queue = {symbol_queue, 5'd25};
      wait_drained();
      repeat (50) @(posedge clock);

      $display("%0d symbols in, %0d results, %0d new nodes, %0d ignored, longest palindrome %0d",
               symbols_in, results_out, new_nodes, overflows, longest);
      $display("text store holds %0d symbols, %0d mismatches", text_len, mismatches);
      if (mismatches == 0 && result_queue.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
`default_nettype wire
